// ===== hw/rtl/lfac_pkg.sv =====
// ----------------------------------------------------------------------------
// lfac_pkg
// Types and constants shared by the line follow / obstacle avoid controller.
// ----------------------------------------------------------------------------
package lfac_pkg;

    // poll item as it arrives
    typedef struct packed {
        logic [31:0] now_ms;
        logic        left_line_raw;
        logic        right_line_raw;
        logic [14:0] left_echo_us;
        logic [14:0] right_echo_us;
    } lfac_in_t;

    // result item
    typedef struct packed {
        logic [3:0] action_code;
        logic [3:0] bridge_bits;
        logic [7:0] left_pwm;
        logic [7:0] right_pwm;
    } lfac_out_t;

    // classified poll held in the queue
    typedef struct packed {
        logic [31:0] now_ms;
        logic        left_on;
        logic        right_on;
        logic [9:0]  left_cm;
        logic [9:0]  right_cm;
    } lfac_cmd_t;

    // configuration registers
    typedef struct packed {
        logic        ir_active_low;
        logic [9:0]  near_limit_cm;
        logic [15:0] range_interval_ms;
        logic [7:0]  cruise_duty;
        logic [7:0]  correct_speed;
        logic [7:0]  reverse_duty;
        logic [7:0]  spin_duty;
        logic [7:0]  hunt_duty;
    } lfac_cfg_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IR_ACTIVE_LOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_IVL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_DUTY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CORRECT_SPEED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_DUTY  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_DUTY     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HUNT_DUTY     = 3'd7;

    localparam lfac_cfg_t CFG_RESET = '{
        ir_active_low:     1'b1,
        near_limit_cm:     10'd15,
        range_interval_ms: 16'd50,
        cruise_duty:       8'd180,
        correct_speed:     8'd140,
        reverse_duty:      8'd170,
        spin_duty:         8'd215,
        hunt_duty:         8'd150
    };

    localparam logic [3:0] ACT_NONE    = 4'd0;
    localparam logic [3:0] ACT_FWD     = 4'd1;
    localparam logic [3:0] ACT_CURVE_L = 4'd2;
    localparam logic [3:0] ACT_CURVE_R = 4'd3;
    localparam logic [3:0] ACT_TURN_L  = 4'd4;
    localparam logic [3:0] ACT_TURN_R  = 4'd5;
    localparam logic [3:0] ACT_BACK    = 4'd6;
    localparam logic [3:0] ACT_SEARCH  = 4'd7;

    localparam logic [3:0] BR_STOP  = 4'h0;
    localparam logic [3:0] BR_FWD   = 4'hA;
    localparam logic [3:0] BR_BACK  = 4'h5;
    localparam logic [3:0] BR_LEFT  = 4'h6;
    localparam logic [3:0] BR_RIGHT = 4'h9;

    localparam int DUR_W = 9;
    localparam logic [DUR_W-1:0] DUR_FWD     = 9'd120;
    localparam logic [DUR_W-1:0] DUR_CORRECT = 9'd120;
    localparam logic [DUR_W-1:0] DUR_SEARCH  = 9'd320;
    localparam logic [DUR_W-1:0] DUR_BACK    = 9'd220;
    localparam logic [DUR_W-1:0] DUR_TURN    = 9'd360;

    // echo * 17 / 1000 as echo * ceil(2^30 * 0.017) >> 30, exact for 15-bit echoes
    localparam int          ECHO_PROD_W   = 40;
    localparam int          ECHO_CM_SHIFT = 30;
    localparam logic [24:0] ECHO_CM_MULT  = 25'd18253612;

    localparam logic [9:0] DIST_RESET = 10'd1000;

endpackage

// ===== hw/rtl/line_follow_avoid_controller.sv =====
// ----------------------------------------------------------------------------
// line_follow_avoid_controller
// Line follower with ultrasonic obstacle avoidance, one result per poll.
// ----------------------------------------------------------------------------
//  channel  ports                      payload
//  s_       s_valid/s_ready/s_data     lfac_in_t: time, line bits, echoes
//  m_       m_valid/m_ready/m_data     lfac_out_t: action, bridge, pwm pair
//  cfg_     cfg_we/cfg_index/cfg_wdata register write, no read-back
//
//  one poll per cycle sustained while results are taken; a poll's result is
//  shown after the queue entry, written at its transfer edge, and the result
//  register; the front classifies polls into a QUEUE_DEPTH entry queue; the
//  back end updates the action state once per cycle from the queue head while
//  not stalled; a stall holds the back end; the queue absorbs polls until full
//  synchronous active-low reset, no clearing pass
// ----------------------------------------------------------------------------
module line_follow_avoid_controller #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  lfac_pkg::lfac_in_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output lfac_pkg::lfac_out_t                  m_data,
    input  logic                                 cfg_we,
    input  logic [lfac_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lfac_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import lfac_pkg::*;

    lfac_cfg_t cfg_reg;
    lfac_cmd_t front_cmd, head_cmd;
    logic      queue_full, queue_not_empty, queue_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_IR_ACTIVE_LOW: cfg_reg.ir_active_low     <= cfg_wdata[0];
                CFG_THRESHOLD:     cfg_reg.near_limit_cm     <= cfg_wdata[9:0];
                CFG_RANGE_IVL:     cfg_reg.range_interval_ms <= cfg_wdata[15:0];
                CFG_CRUISE_DUTY:   cfg_reg.cruise_duty       <= cfg_wdata[7:0];
                CFG_CORRECT_SPEED: cfg_reg.correct_speed     <= cfg_wdata[7:0];
                CFG_REVERSE_DUTY:  cfg_reg.reverse_duty      <= cfg_wdata[7:0];
                CFG_SPIN_DUTY:     cfg_reg.spin_duty         <= cfg_wdata[7:0];
                CFG_HUNT_DUTY:     cfg_reg.hunt_duty         <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    assign s_ready = !queue_full;

    lfac_front u_front (
        .in_data       (s_data),
        .ir_active_low (cfg_reg.ir_active_low),
        .cmd           (front_cmd)
    );

    lfac_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid),
        .push_data (front_cmd),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .head      (head_cmd)
    );

    lfac_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_valid (queue_not_empty),
        .cmd       (head_cmd),
        .pop       (queue_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== hw/rtl/lfac_front.sv =====
// ----------------------------------------------------------------------------
// lfac_front
// Classifies a poll: line sensor polarity and echo to centimeter conversion.
// ----------------------------------------------------------------------------
module lfac_front (
    input  lfac_pkg::lfac_in_t  in_data,
    input  logic                ir_active_low,
    output lfac_pkg::lfac_cmd_t cmd
);
    import lfac_pkg::*;

    logic [ECHO_PROD_W-1:0] left_prod;
    logic [ECHO_PROD_W-1:0] right_prod;

    assign left_prod  = ECHO_PROD_W'(in_data.left_echo_us) * ECHO_PROD_W'(ECHO_CM_MULT);
    assign right_prod = ECHO_PROD_W'(in_data.right_echo_us) * ECHO_PROD_W'(ECHO_CM_MULT);

    always_comb begin
        cmd.now_ms   = in_data.now_ms;
        cmd.left_on  = in_data.left_line_raw ^ ir_active_low;
        cmd.right_on = in_data.right_line_raw ^ ir_active_low;
        cmd.left_cm  = left_prod[ECHO_CM_SHIFT +: 10];
        cmd.right_cm = right_prod[ECHO_CM_SHIFT +: 10];
    end

endmodule

// ===== hw/rtl/lfac_queue.sv =====
// ----------------------------------------------------------------------------
// lfac_queue
// Small register queue between the classifying front and the action back end.
// ----------------------------------------------------------------------------
module lfac_queue #(
    parameter int DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  lfac_pkg::lfac_cmd_t push_data,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output lfac_pkg::lfac_cmd_t head
);
    import lfac_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lfac_cmd_t          store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = store_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

endmodule

// ===== hw/rtl/lfac_back.sv =====
// ----------------------------------------------------------------------------
// lfac_back
// Ranging latch, obstacle test and action selection, with the result register.
// ----------------------------------------------------------------------------
module lfac_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  lfac_pkg::lfac_cfg_t cfg,
    input  logic                cmd_valid,
    input  lfac_pkg::lfac_cmd_t cmd,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output lfac_pkg::lfac_out_t m_data
);
    import lfac_pkg::*;

    lfac_out_t          out_reg, out_next;
    logic               m_valid_reg, m_valid_next;
    logic [31:0]        end_reg, end_next;
    logic [31:0]        last_range_reg;
    logic [9:0]         ldist_reg, rdist_reg;
    logic [31:0]        since_range;
    logic               latch;
    logic [9:0]         ldist, rdist;
    logic               lclose, rclose, obstacle, hold, start;
    logic [DUR_W-1:0]   dur;

    assign pop         = cmd_valid && (!m_valid_reg || m_ready);
    assign since_range = cmd.now_ms - last_range_reg;
    assign latch       = since_range >= {16'd0, cfg.range_interval_ms};
    assign ldist       = latch ? cmd.left_cm : ldist_reg;
    assign rdist       = latch ? cmd.right_cm : rdist_reg;
    assign lclose      = ldist <= cfg.near_limit_cm;
    assign rclose      = rdist <= cfg.near_limit_cm;
    assign obstacle    = (lclose && ldist != '0) || (rclose && rdist != '0);
    assign hold        = end_reg > cmd.now_ms;

    always_comb begin
        out_next = out_reg;
        start    = 1'b1;
        dur      = DUR_FWD;
        if (obstacle) begin
            if (lclose && rclose) begin
                out_next = '{ACT_BACK, BR_BACK, cfg.reverse_duty, cfg.reverse_duty};
                dur      = DUR_BACK;
            end else if (rclose) begin
                out_next = '{ACT_TURN_L, BR_LEFT, cfg.spin_duty, cfg.spin_duty};
                dur      = DUR_TURN;
            end else begin
                out_next = '{ACT_TURN_R, BR_RIGHT, cfg.spin_duty, cfg.spin_duty};
                dur      = DUR_TURN;
            end
        end else if (!hold) begin
            if (cmd.left_on && cmd.right_on) begin
                out_next = '{ACT_FWD, BR_FWD, cfg.cruise_duty, cfg.cruise_duty};
                dur      = DUR_FWD;
            end else if (cmd.left_on) begin
                out_next = '{ACT_CURVE_L, BR_FWD, cfg.correct_speed, cfg.cruise_duty};
                dur      = DUR_CORRECT;
            end else if (cmd.right_on) begin
                out_next = '{ACT_CURVE_R, BR_FWD, cfg.cruise_duty, cfg.correct_speed};
                dur      = DUR_CORRECT;
            end else begin
                out_next = '{ACT_SEARCH, BR_FWD, cfg.hunt_duty, cfg.correct_speed};
                dur      = DUR_SEARCH;
            end
        end else begin
            start = 1'b0;
        end
        end_next = start ? (cmd.now_ms + {{(32 - DUR_W){1'b0}}, dur}) : end_reg;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            out_reg        <= '{ACT_NONE, BR_STOP, 8'd0, 8'd0};
            end_reg        <= '0;
            last_range_reg <= '0;
            ldist_reg      <= DIST_RESET;
            rdist_reg      <= DIST_RESET;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                out_reg <= out_next;
                end_reg <= end_next;
                if (latch) begin
                    last_range_reg <= cmd.now_ms;
                    ldist_reg      <= cmd.left_cm;
                    rdist_reg      <= cmd.right_cm;
                end
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assert property (@(posedge aclk) disable iff (!aresetn) pop |=> m_valid_reg)
        else $error("popped command left no result");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && latch) |=> (last_range_reg == $past(cmd.now_ms)))
        else $error("range latch time not updated");
    assert property (@(posedge aclk) disable iff (!aresetn)
        !pop |=> ($stable(end_reg) && $stable(out_reg)))
        else $error("action state changed without a command");

endmodule

// ===== dv/lfac_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lfac_checker
// Watches the poll, result and register ports of the line follow / obstacle
// avoid controller. Every poll transfer runs through a local copy of the
// ranging, obstacle and action logic to form the expected result; every
// result transfer is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module lfac_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  lfac_pkg::lfac_in_t                  s_data,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  lfac_pkg::lfac_out_t                 m_data,
    input  logic                                cfg_we,
    input  logic [lfac_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lfac_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output int                                  fail_count,
    output int                                  pending_moves
);
    import lfac_pkg::*;

    localparam logic [31:0] FOLLOW_MS = 32'd120;
    localparam logic [31:0] SEARCH_MS = 32'd320;
    localparam logic [31:0] BACK_MS   = 32'd220;
    localparam logic [31:0] TURN_MS   = 32'd360;
    localparam int          REPORT_MAX = 10;

    lfac_cfg_t   cfg;
    logic [3:0]  move_code;
    logic [31:0] move_end_ms;
    logic [31:0] last_range_ms;
    logic [9:0]  left_cm;
    logic [9:0]  right_cm;
    logic [3:0]  bridge;
    logic [7:0]  left_duty;
    logic [7:0]  right_duty;
    lfac_out_t   expected_moves[$];

    function automatic logic [9:0] echo_to_cm(input logic [14:0] echo);
        logic [31:0] prod;
        prod = 32'(echo) * 32'd17;
        return 10'(prod / 32'd1000);
    endfunction

    task automatic start_move(input logic [3:0] code, input logic [3:0] br,
                              input logic [7:0] lp, input logic [7:0] rp,
                              input logic [31:0] dur, input logic [31:0] now);
        move_code   = code;
        bridge      = br;
        left_duty   = lp;
        right_duty  = rp;
        move_end_ms = now + dur;
    endtask

    task automatic predict_move(input lfac_in_t poll);
        logic [31:0] since;
        logic        left_on;
        logic        right_on;
        logic        left_near;
        logic        right_near;
        lfac_out_t   want;
        since = poll.now_ms - last_range_ms;
        if (since >= 32'(cfg.range_interval_ms)) begin
            left_cm       = echo_to_cm(poll.left_echo_us);
            right_cm      = echo_to_cm(poll.right_echo_us);
            last_range_ms = poll.now_ms;
        end
        left_on    = cfg.ir_active_low ? ~poll.left_line_raw : poll.left_line_raw;
        right_on   = cfg.ir_active_low ? ~poll.right_line_raw : poll.right_line_raw;
        left_near  = left_cm <= cfg.near_limit_cm;
        right_near = right_cm <= cfg.near_limit_cm;
        // a zero distance is a timeout: it cannot raise an obstacle on its own
        if ((left_near && left_cm != 0) || (right_near && right_cm != 0)) begin
            if (left_near && right_near)
                start_move(ACT_BACK, BR_BACK, cfg.reverse_duty, cfg.reverse_duty,
                           BACK_MS, poll.now_ms);
            else if (right_near)
                start_move(ACT_TURN_L, BR_LEFT, cfg.spin_duty, cfg.spin_duty,
                           TURN_MS, poll.now_ms);
            else
                start_move(ACT_TURN_R, BR_RIGHT, cfg.spin_duty, cfg.spin_duty,
                           TURN_MS, poll.now_ms);
        end else if (!(move_end_ms > poll.now_ms)) begin
            if (left_on && right_on)
                start_move(ACT_FWD, BR_FWD, cfg.cruise_duty, cfg.cruise_duty,
                           FOLLOW_MS, poll.now_ms);
            else if (left_on)
                start_move(ACT_CURVE_L, BR_FWD, cfg.correct_speed, cfg.cruise_duty,
                           FOLLOW_MS, poll.now_ms);
            else if (right_on)
                start_move(ACT_CURVE_R, BR_FWD, cfg.cruise_duty, cfg.correct_speed,
                           FOLLOW_MS, poll.now_ms);
            else
                start_move(ACT_SEARCH, BR_FWD, cfg.hunt_duty, cfg.correct_speed,
                           SEARCH_MS, poll.now_ms);
        end
        want.action_code = move_code;
        want.bridge_bits = bridge;
        want.left_pwm    = left_duty;
        want.right_pwm   = right_duty;
        expected_moves.push_back(want);
    endtask

    task automatic check_move(input lfac_out_t got);
        lfac_out_t want;
        if (expected_moves.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("%0t: result transfer with nothing expected: %h", $time, got);
        end else begin
            want = expected_moves.pop_front();
            if (got.action_code !== want.action_code || got.bridge_bits !== want.bridge_bits ||
                got.left_pwm !== want.left_pwm || got.right_pwm !== want.right_pwm) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display(
                        "%0t: mismatch: expected %0d/%h/%0d/%0d got %0d/%h/%0d/%0d",
                        $time, want.action_code, want.bridge_bits, want.left_pwm,
                        want.right_pwm, got.action_code, got.bridge_bits,
                        got.left_pwm, got.right_pwm);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_IR_ACTIVE_LOW: cfg.ir_active_low     = data[0];
            CFG_THRESHOLD:     cfg.near_limit_cm     = data[9:0];
            CFG_RANGE_IVL:     cfg.range_interval_ms = data;
            CFG_CRUISE_DUTY:   cfg.cruise_duty       = data[7:0];
            CFG_CORRECT_SPEED: cfg.correct_speed     = data[7:0];
            CFG_REVERSE_DUTY:  cfg.reverse_duty      = data[7:0];
            CFG_SPIN_DUTY:     cfg.spin_duty         = data[7:0];
            CFG_HUNT_DUTY:     cfg.hunt_duty         = data[7:0];
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            fail_count    = 0;
            cfg           = CFG_RESET;
            move_code     = ACT_NONE;
            move_end_ms   = '0;
            last_range_ms = '0;
            left_cm       = 10'd1000;
            right_cm      = 10'd1000;
            bridge        = BR_STOP;
            left_duty     = '0;
            right_duty    = '0;
            expected_moves.delete();
        end else begin
            if (m_valid && m_ready)
                check_move(m_data);
            if (s_valid && s_ready)
                predict_move(s_data);
            if (cfg_we)
                write_reg(cfg_index, cfg_wdata);
        end
        pending_moves = expected_moves.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives polls into the line follow / obstacle avoid controller: a directed
// walk through line following, timeouts, threshold edges, avoidance choices
// and the 32-bit time wrap, then random drives under several register
// settings with random gaps, random result stalls and one long stall that
// backs the poll queue up. lfac_checker predicts and compares the results.
// ----------------------------------------------------------------------------
module testbench;
    import lfac_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    lfac_in_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    lfac_out_t             m_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int          fail_count;
    int          pending_moves;
    int          cycle_count = 0;
    logic [31:0] poll_ms;
    bit          tx_quiet;
    bit          hold_go;

    line_follow_avoid_controller uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    lfac_checker move_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_moves (pending_moves)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic send_poll(input lfac_in_t poll);
        int gap;
        s_data  <= poll;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_fixed(input logic [31:0] now, input logic l_raw, input logic r_raw,
                              input logic [14:0] l_echo, input logic [14:0] r_echo);
        lfac_in_t poll;
        poll.now_ms         = now;
        poll.left_line_raw  = l_raw;
        poll.right_line_raw = r_raw;
        poll.left_echo_us   = l_echo;
        poll.right_echo_us  = r_echo;
        send_poll(poll);
    endtask

    function automatic logic [14:0] draw_echo();
        logic [14:0] echo;
        case ($urandom_range(0, 9))
            0:       echo = '0;
            1:       echo = 15'($urandom_range(1, 1200));
            2:       echo = 15'($urandom_range(0, 32767));
            default: echo = 15'($urandom_range(1200, 30000));
        endcase
        return echo;
    endfunction

    // mostly a drive with advancing time, sometimes a poll from anywhere
    task automatic make_poll(output lfac_in_t poll);
        if ($urandom_range(0, 9) == 0) begin
            poll.now_ms        = $urandom();
            poll.left_echo_us  = 15'($urandom_range(0, 32767));
            poll.right_echo_us = 15'($urandom_range(0, 32767));
        end else begin
            if ($urandom_range(0, 199) == 0)
                poll_ms = 32'hFFFF_FE00 + $urandom_range(0, 255);
            else if ($urandom_range(0, 9) == 0)
                poll_ms = poll_ms + $urandom_range(100, 400);
            else
                poll_ms = poll_ms + $urandom_range(0, 60);
            poll.now_ms        = poll_ms;
            poll.left_echo_us  = draw_echo();
            poll.right_echo_us = draw_echo();
        end
        poll.left_line_raw  = 1'($urandom_range(0, 1));
        poll.right_line_raw = 1'($urandom_range(0, 1));
    endtask

    task automatic run_random(input int count, input bit with_hold);
        lfac_in_t poll;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0)
                tx_quiet = ($urandom_range(0, 2) == 0);
            if (with_hold && i >= 50 && i < 100)
                tx_quiet = 1'b1;
            if (with_hold && i == 50)
                hold_go = 1'b1;
            make_poll(poll);
            send_poll(poll);
        end
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic write_settings(input lfac_cfg_t c);
        set_reg(CFG_IR_ACTIVE_LOW, 16'(c.ir_active_low));
        set_reg(CFG_THRESHOLD,     16'(c.near_limit_cm));
        set_reg(CFG_RANGE_IVL,     c.range_interval_ms);
        set_reg(CFG_CRUISE_DUTY,   16'(c.cruise_duty));
        set_reg(CFG_CORRECT_SPEED, 16'(c.correct_speed));
        set_reg(CFG_REVERSE_DUTY,  16'(c.reverse_duty));
        set_reg(CFG_SPIN_DUTY,     16'(c.spin_duty));
        set_reg(CFG_HUNT_DUTY,     16'(c.hunt_duty));
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic lfac_cfg_t random_settings();
        lfac_cfg_t c;
        c.ir_active_low     = 1'($urandom_range(0, 1));
        c.near_limit_cm     = 10'($urandom_range(5, 40));
        c.range_interval_ms = 16'($urandom_range(0, 120));
        c.cruise_duty       = 8'($urandom_range(0, 255));
        c.correct_speed     = 8'($urandom_range(0, 255));
        c.reverse_duty      = 8'($urandom_range(0, 255));
        c.spin_duty         = 8'($urandom_range(0, 255));
        c.hunt_duty         = 8'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_moves != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // result side: random stalls per transfer, plus one long hold-off
    initial begin : receiver
        int w;
        int rx_cnt;
        int hold_cnt;
        int rx_moves;
        bit rx_quiet;
        bit hold_done;
        bit nxt;
        rx_cnt    = 0;
        hold_cnt  = 0;
        rx_moves  = 0;
        rx_quiet  = 1'b0;
        hold_done = 1'b0;
        m_ready   = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                rx_moves++;
                if (rx_moves % 40 == 0)
                    rx_quiet = ($urandom_range(0, 2) == 0);
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                nxt = (hold_cnt == 0);
            end else if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                hold_cnt  = HOLD_CYCLES;
                nxt       = 1'b0;
            end else if (m_valid && m_ready) begin
                w      = rx_quiet ? 0 : $urandom_range(0, 19);
                rx_cnt = w;
                nxt    = (w == 0);
            end else if (rx_cnt > 0) begin
                rx_cnt--;
                nxt = (rx_cnt == 0);
            end else begin
                nxt = 1'b1;
            end
            m_ready <= nxt;
        end
    end

    initial begin
        lfac_cfg_t c;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        poll_ms   = '0;
        tx_quiet  = 1'b0;
        hold_go   = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: line following, timeouts, threshold edges, avoidance
        send_fixed(32'd0,    1'b0, 1'b0, 15'd5000,  15'd5000);
        send_fixed(32'd60,   1'b0, 1'b0, 15'd5000,  15'd5000);
        send_fixed(32'd130,  1'b0, 1'b1, 15'd5000,  15'd5000);
        send_fixed(32'd250,  1'b1, 1'b0, 15'd5000,  15'd5000);
        send_fixed(32'd370,  1'b1, 1'b1, 15'd5000,  15'd5000);
        send_fixed(32'd700,  1'b1, 1'b1, 15'd0,     15'd0);
        send_fixed(32'd760,  1'b0, 1'b0, 15'd882,   15'd5000);
        send_fixed(32'd820,  1'b0, 1'b0, 15'd5000,  15'd941);
        send_fixed(32'd880,  1'b0, 1'b0, 15'd942,   15'd5000);
        send_fixed(32'd940,  1'b0, 1'b0, 15'd500,   15'd500);
        send_fixed(32'd1000, 1'b0, 1'b0, 15'd0,     15'd600);
        send_fixed(32'd1020, 1'b0, 1'b0, 15'd30000, 15'd30000);
        send_fixed(32'd1100, 1'b0, 1'b0, 15'd30000, 15'd30000);
        send_fixed(32'd1250, 1'b0, 1'b0, 15'd32767, 15'd32767);
        send_fixed(32'd1260, 1'b1, 1'b1, 15'd32767, 15'd0);
        // time wrap: end time wraps past zero, hold compare has no wrap handling
        send_fixed(32'hFFFF_FFA0, 1'b0, 1'b0, 15'd20000, 15'd20000);
        send_fixed(32'hFFFF_FFF0, 1'b1, 1'b0, 15'd20000, 15'd20000);
        send_fixed(32'hFFFF_FFFF, 1'b1, 1'b1, 15'd1,     15'd1);
        send_fixed(32'd0,    1'b0, 1'b0, 15'd700,   15'd32767);
        send_fixed(32'h60,   1'b0, 1'b0, 15'd700,   15'd32767);
        send_fixed(32'h70,   1'b0, 1'b0, 15'd0,     15'd0);
        send_fixed(32'h100,  1'b1, 1'b0, 15'd0,     15'd0);
        send_fixed(32'h300,  1'b0, 1'b1, 15'd0,     15'd0);
        wait_idle();

        // low extremes: active-high sensors, widest threshold, no interval
        c = '0;
        c.near_limit_cm = 10'd1023;
        write_settings(c);
        run_random(150, 1'b0);
        wait_idle();

        // high extremes: zero threshold, longest interval, full speeds
        c.ir_active_low     = 1'b1;
        c.near_limit_cm     = 10'd0;
        c.range_interval_ms = 16'hFFFF;
        c.cruise_duty       = 8'hFF;
        c.correct_speed     = 8'hFF;
        c.reverse_duty      = 8'hFF;
        c.spin_duty         = 8'hFF;
        c.hunt_duty         = 8'hFF;
        write_settings(c);
        run_random(150, 1'b0);
        wait_idle();

        write_settings(random_settings());
        run_random(170, 1'b1);
        wait_idle();

        write_settings(random_settings());
        run_random(170, 1'b0);
        wait_idle();

        write_settings(CFG_RESET);
        run_random(160, 1'b0);
        wait_idle();
        repeat (8) @(posedge aclk);

        if (fail_count == 0 && pending_moves == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
